// File: sv/bdrl_pkg.sv
// ----------------------------------------------------------------------------
// bdrl_pkg: shared definitions for the box downscaler
// Widths, register indexes, the queued box record and the back-end states.
// ----------------------------------------------------------------------------
package bdrl_pkg;

   localparam int MAX_LINE_WIDTH = 4096;
   localparam int COMP_BITS      = 16;
   localparam int CHANNELS       = 3;

   // Width registers hold 1..MAX_LINE_WIDTH, so one bit more than the index range.
   localparam int WIDTH_BITS     = $clog2(MAX_LINE_WIDTH) + 1;
   // Cross-multiplied positions reach MAX_LINE_WIDTH squared.
   localparam int POS_BITS       = 2 * WIDTH_BITS - 1;
   // A box holds at most MAX_LINE_WIDTH pixels of full-scale components.
   localparam int SUM_BITS       = COMP_BITS + WIDTH_BITS - 1;
   localparam int CNT_BITS       = WIDTH_BITS;

   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);

   localparam int STEP_BITS      = $clog2(COMP_BITS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(COMP_BITS - 1);

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_WIDTH = 1'b1;

   typedef logic [SUM_BITS-1:0] sum_type;

   // One closed box, waiting for its averages to be computed.
   typedef struct packed {
      sum_type [CHANNELS-1:0] sums;
      logic [CNT_BITS-1:0]    count;
      logic                   last;
   } box_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RUN,
      BACK_DONE
   } back_state_type;

endpackage

// File: sv/bdrl_front.sv
// ----------------------------------------------------------------------------
// bdrl_front: pixel intake and box classification
// Holds the width registers, accumulates channel sums and decides on each
// pixel whether it closes a box; closed boxes are pushed into the queue.
// ----------------------------------------------------------------------------
module bdrl_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bdrl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bdrl_pkg::WIDTH_BITS-1:0]      csr_wdata,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [bdrl_pkg::CHANNELS-1:0][bdrl_pkg::COMP_BITS-1:0] in_comp,
   input  logic                                 fifo_full,
   output logic                                 push,
   output bdrl_pkg::box_type                    push_box
);

   function automatic logic [bdrl_pkg::WIDTH_BITS-1:0] clamp_width(
      input logic [bdrl_pkg::WIDTH_BITS-1:0] w
   );
      logic [bdrl_pkg::WIDTH_BITS-1:0] r;
      r = w;
      if (w == '0) begin
         r = bdrl_pkg::WIDTH_BITS'(1);
      end else if (w > bdrl_pkg::WIDTH_BITS'(bdrl_pkg::MAX_LINE_WIDTH)) begin
         r = bdrl_pkg::WIDTH_BITS'(bdrl_pkg::MAX_LINE_WIDTH);
      end
      return r;
   endfunction

   logic [bdrl_pkg::WIDTH_BITS-1:0] src_w_ff, src_w_in;
   logic [bdrl_pkg::WIDTH_BITS-1:0] tgt_w_ff, tgt_w_in;
   logic [bdrl_pkg::POS_BITS-1:0]   pos_ff, pos_in;
   logic [bdrl_pkg::POS_BITS-1:0]   bound_ff, bound_in;
   bdrl_pkg::sum_type [bdrl_pkg::CHANNELS-1:0] sums_ff, sums_in, sums_next;
   logic [bdrl_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in, cnt_next;
   logic [bdrl_pkg::CNT_BITS-1:0]   emitted_ff, emitted_in, emitted_next;
   logic [bdrl_pkg::POS_BITS-1:0]   pos_next;
   logic                            accept;
   logic                            close;
   logic                            last;

   always_comb begin
      accept       = in_valid && !fifo_full;
      for (int c = 0; c < bdrl_pkg::CHANNELS; c++) begin
         sums_next[c] = sums_ff[c] + bdrl_pkg::SUM_BITS'(in_comp[c]);
      end
      cnt_next     = cnt_ff + bdrl_pkg::CNT_BITS'(1);
      pos_next     = pos_ff + bdrl_pkg::POS_BITS'(tgt_w_ff);
      close        = pos_next >= bound_ff;
      emitted_next = emitted_ff + bdrl_pkg::CNT_BITS'(1);
      last         = emitted_next >= tgt_w_ff;
   end

   assign in_ready       = !fifo_full;
   assign push           = accept && close;
   assign push_box.sums  = sums_next;
   assign push_box.count = cnt_next;
   assign push_box.last  = last;

   always_comb begin
      src_w_in   = src_w_ff;
      tgt_w_in   = tgt_w_ff;
      pos_in     = pos_ff;
      bound_in   = bound_ff;
      sums_in    = sums_ff;
      cnt_in     = cnt_ff;
      emitted_in = emitted_ff;
      if (csr_we) begin
         case (csr_index)
            bdrl_pkg::CSR_SOURCE_WIDTH: src_w_in = clamp_width(csr_wdata);
            bdrl_pkg::CSR_TARGET_WIDTH: tgt_w_in = clamp_width(csr_wdata);
            default: ;
         endcase
         // Any register write restarts the line.
         pos_in     = '0;
         bound_in   = bdrl_pkg::POS_BITS'(src_w_in);
         sums_in    = '0;
         cnt_in     = '0;
         emitted_in = '0;
      end else if (accept) begin
         if (close) begin
            sums_in = '0;
            cnt_in  = '0;
            if (last) begin
               pos_in     = '0;
               bound_in   = bdrl_pkg::POS_BITS'(src_w_ff);
               emitted_in = '0;
            end else begin
               pos_in     = pos_next;
               bound_in   = bound_ff + bdrl_pkg::POS_BITS'(src_w_ff);
               emitted_in = emitted_next;
            end
         end else begin
            sums_in = sums_next;
            cnt_in  = cnt_next;
            pos_in  = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff   <= bdrl_pkg::WIDTH_BITS'(1);
         tgt_w_ff   <= bdrl_pkg::WIDTH_BITS'(1);
         pos_ff     <= '0;
         bound_ff   <= bdrl_pkg::POS_BITS'(1);
         sums_ff    <= '0;
         cnt_ff     <= '0;
         emitted_ff <= '0;
      end else begin
         src_w_ff   <= src_w_in;
         tgt_w_ff   <= tgt_w_in;
         pos_ff     <= pos_in;
         bound_ff   <= bound_in;
         sums_ff    <= sums_in;
         cnt_ff     <= cnt_in;
         emitted_ff <= emitted_in;
      end
   end

endmodule

// File: sv/bdrl_fifo.sv
// ----------------------------------------------------------------------------
// bdrl_fifo: short queue of closed boxes
// Decouples pixel intake from the dividers.
// ----------------------------------------------------------------------------
module bdrl_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bdrl_pkg::box_type push_box,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output bdrl_pkg::box_type pop_box
);

   bdrl_pkg::box_type                mem_ff [bdrl_pkg::FIFO_DEPTH];
   logic [bdrl_pkg::FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bdrl_pkg::FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bdrl_pkg::FIFO_PTR_BITS:0]   count_ff, count_in;

   assign full    = count_ff == (bdrl_pkg::FIFO_PTR_BITS+1)'(bdrl_pkg::FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_box = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + bdrl_pkg::FIFO_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + bdrl_pkg::FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (bdrl_pkg::FIFO_PTR_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (bdrl_pkg::FIFO_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_box;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/bdrl_back.sv
// ----------------------------------------------------------------------------
// bdrl_back: box averaging and result register
// Three restoring dividers share one step counter and retire one quotient
// bit per channel per cycle; the result register frees them for the next box.
// ----------------------------------------------------------------------------
module bdrl_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              fifo_empty,
   input  bdrl_pkg::box_type fifo_box,
   output logic              fifo_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [bdrl_pkg::CHANNELS*bdrl_pkg::COMP_BITS-1:0] rsp_tdata,
   output logic              rsp_tlast
);

   bdrl_pkg::back_state_type        state_ff, state_in;
   logic [bdrl_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic [bdrl_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                            last_ff, last_in;
   logic [bdrl_pkg::CHANNELS-1:0][bdrl_pkg::CNT_BITS-1:0]  rem_ff, rem_in, rem_step;
   logic [bdrl_pkg::CHANNELS-1:0][bdrl_pkg::COMP_BITS-1:0] quo_ff, quo_in, quo_step;
   logic [bdrl_pkg::CHANNELS-1:0][bdrl_pkg::COMP_BITS-1:0] out_data_ff, out_data_in;
   logic                            out_last_ff, out_last_in;
   logic                            out_valid_ff, out_valid_in;
   logic [bdrl_pkg::CNT_BITS:0]     trial;
   logic                            fits;
   logic                            out_free;
   logic                            load_out;

   // One restoring step per channel. The remainder stays below the count.
   always_comb begin
      trial = '0;
      fits  = 1'b0;
      for (int c = 0; c < bdrl_pkg::CHANNELS; c++) begin
         trial       = {rem_ff[c], quo_ff[c][bdrl_pkg::COMP_BITS-1]};
         fits        = trial >= {1'b0, cnt_ff};
         rem_step[c] = fits ? bdrl_pkg::CNT_BITS'(trial - {1'b0, cnt_ff})
                            : trial[bdrl_pkg::CNT_BITS-1:0];
         quo_step[c] = {quo_ff[c][bdrl_pkg::COMP_BITS-2:0], fits};
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      fifo_pop     = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         bdrl_pkg::BACK_IDLE: begin
            fifo_pop = !fifo_empty;
         end
         bdrl_pkg::BACK_RUN: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff + bdrl_pkg::STEP_BITS'(1);
            if (step_ff == bdrl_pkg::STEP_LAST) begin
               state_in = bdrl_pkg::BACK_DONE;
            end
         end
         bdrl_pkg::BACK_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               fifo_pop = !fifo_empty;
               state_in = bdrl_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = bdrl_pkg::BACK_IDLE;
         end
      endcase
      if (fifo_pop) begin
         // The quotient fits the component width, so the upper sum bits
         // are already a valid starting remainder.
         state_in = bdrl_pkg::BACK_RUN;
         step_in  = '0;
         cnt_in   = fifo_box.count;
         last_in  = fifo_box.last;
         for (int c = 0; c < bdrl_pkg::CHANNELS; c++) begin
            rem_in[c] = bdrl_pkg::CNT_BITS'(
               fifo_box.sums[c][bdrl_pkg::SUM_BITS-1:bdrl_pkg::COMP_BITS]);
            quo_in[c] = fifo_box.sums[c][bdrl_pkg::COMP_BITS-1:0];
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_data_in  = quo_ff;
         out_last_in  = last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdrl_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   a_run_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == bdrl_pkg::BACK_RUN |-> cnt_ff != '0)
      else $error("divider running on an empty box");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdrl_pkg::BACK_RUN && step_ff == bdrl_pkg::STEP_LAST)
      |=> state_ff == bdrl_pkg::BACK_DONE)
      else $error("divider did not finish after the last quotient bit");

   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> (!fifo_empty && state_ff != bdrl_pkg::BACK_RUN))
      else $error("box taken from the queue while dividing or queue empty");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdrl_pkg::BACK_DONE && out_free) |=> out_valid_ff)
      else $error("finished average not moved to the result register");

endmodule

// File: sv/box_downscale_rgb_line_core.sv
// ----------------------------------------------------------------------------
// box_downscale_rgb_line_core: horizontal box-average RGB line downscaler
// Shrinks a line of source_width pixels to target_width pixels by averaging.
// ----------------------------------------------------------------------------
// Usage:
// Source pixels arrive as req beats, one 16-bit red, green and blue component
// each. Every pixel is added into running channel sums. A pixel that carries
// the source position up to the current output boundary closes a box, and the
// average of that box later leaves as one rsp beat; rsp_tlast marks the last
// output pixel of a line, after which the next line starts on its own.
// The two width registers are written through csr_we/csr_index/csr_wdata.
// Values are clamped to 1..4096, and any write restarts the line.
// The intake takes one pixel per clock as long as its four-entry box queue
// has room. Each box then runs through the restoring dividers (one quotient
// bit per cycle for all three channels) and moves on to the result
// register; the step that loads it also takes the next queued box, if any.
// A stalled rsp_tready holds the result register while the dividers finish
// the next box; once the queue fills, req_tready drops.
// Synchronous reset sets both widths to 1 and clears all line state.
// ----------------------------------------------------------------------------
module box_downscale_rgb_line_core (
   input  logic                                clock,
   input  logic                                reset,
   // Width register write port.
   input  logic                                csr_we,
   input  logic [bdrl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bdrl_pkg::WIDTH_BITS-1:0]     csr_wdata,
   // Source pixels.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata fields, low to high: in_red, in_green, in_blue.
   input  logic [bdrl_pkg::CHANNELS*bdrl_pkg::COMP_BITS-1:0] req_tdata,
   // Averaged pixels.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata fields, low to high: out_red, out_green, out_blue.
   output logic [bdrl_pkg::CHANNELS*bdrl_pkg::COMP_BITS-1:0] rsp_tdata,
   output logic                                rsp_tlast
);

   // Components in channel order red, green, blue, red in the lowest bits.
   logic [bdrl_pkg::CHANNELS-1:0][bdrl_pkg::COMP_BITS-1:0] in_comp;
   logic              fifo_full;
   logic              fifo_empty;
   logic              push;
   logic              pop;
   bdrl_pkg::box_type push_box;
   bdrl_pkg::box_type pop_box;

   assign in_comp = req_tdata;

   // The front end tracks positions and sums and decides where boxes close.
   bdrl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_comp   (in_comp),
      .fifo_full (fifo_full),
      .push      (push),
      .push_box  (push_box)
   );

   // Closed boxes wait here so intake keeps going while the dividers work.
   bdrl_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_box (push_box),
      .full     (fifo_full),
      .pop      (pop),
      .empty    (fifo_empty),
      .pop_box  (pop_box)
   );

   // The back end divides each sum by the pixel count and presents the beat.
   bdrl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_box   (pop_box),
      .fifo_pop   (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
